/* hw/rtl/imm_pkg.sv */
// ----------------------------------------------------------------------------
// imm_pkg
// Shared widths, request and register codes, and chain types for the integer
// matrix multiplier.
// ----------------------------------------------------------------------------
package imm_pkg;

  localparam int IDX_W       = 4;   // row and column indexes
  localparam int DIM_W       = 5;   // size registers
  localparam int VAL_W       = 16;  // loaded element value
  localparam int START_W     = 32;  // start value register
  localparam int SUM_W       = 40;  // product element
  localparam int REQ_W       = 2;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 32;
  localparam int INDEX_LIMIT = 16;  // largest size reachable by 4-bit indexes

  localparam logic [REQ_W-1:0] REQ_LOAD_A  = 2'd0;
  localparam logic [REQ_W-1:0] REQ_LOAD_B  = 2'd1;
  localparam logic [REQ_W-1:0] REQ_COMPUTE = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_A_ROWS = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_A_COLS = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_B_ROWS = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_B_COLS = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_START  = 3'd4;

  // Broadcast control for every cell of the chain
  typedef struct packed {
    logic clr;    // load the start value into the accumulator
    logic shift;  // take the accumulator of the right-hand neighbor
  } ctl_t;

  // Term tag traveling along the chain with the A element
  typedef struct packed {
    logic             valid;
    logic [IDX_W-1:0] k;
  } tag_t;

endpackage

/* hw/rtl/imm_ram.sv */
// ----------------------------------------------------------------------------
// imm_ram
// Generic simple dual-port RAM: one write port, one read port, registered
// read data.
// ----------------------------------------------------------------------------
module imm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* hw/rtl/imm_cell.sv */
// ----------------------------------------------------------------------------
// imm_cell
// One product column of the multiplier. Holds its column of B, multiplies the
// A element passing through by B[k][col], accumulates, and forwards the A
// element to the next cell. During output the accumulators shift left.
// ----------------------------------------------------------------------------
module imm_cell #(
  parameter int DATA_WIDTH = 16,
  parameter int EFF_DIM    = 16,
  parameter int COL        = 0
) (
  input  logic                               clk,
  input  logic                               rst,
  input  imm_pkg::ctl_t                      ctl,
  input  logic signed [imm_pkg::SUM_W-1:0]   start_sum,
  input  logic                               b_we,
  input  logic [imm_pkg::IDX_W-1:0]          b_row,
  input  logic [imm_pkg::IDX_W-1:0]          b_col,
  input  logic [DATA_WIDTH-1:0]              b_data,
  input  imm_pkg::tag_t                      tag_in,
  input  logic signed [DATA_WIDTH-1:0]       a_in,
  output imm_pkg::tag_t                      tag_out,
  output logic signed [DATA_WIDTH-1:0]       a_out,
  input  logic signed [imm_pkg::SUM_W-1:0]   acc_in,
  output logic signed [imm_pkg::SUM_W-1:0]   acc_out
);

  localparam int KW = (EFF_DIM > 1) ? $clog2(EFF_DIM) : 1;
  localparam int SW = imm_pkg::SUM_W;
  localparam int PW = 2 * DATA_WIDTH;

  logic                         vld_q;
  logic [imm_pkg::IDX_W-1:0]    k_q;
  logic signed [DATA_WIDTH-1:0] a_q;
  logic signed [DATA_WIDTH-1:0] b_rd;
  logic                         p_vld;
  logic signed [PW-1:0]         prod;
  logic signed [SW-1:0]         acc;
  logic                         col_hit;

  assign col_hit = b_we && (b_col == imm_pkg::IDX_W'(COL));

  imm_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (EFF_DIM)
  ) u_bcol (
    .clk   (clk),
    .we    (col_hit),
    .waddr (KW'(b_row)),
    .wdata (b_data),
    .raddr (KW'(tag_in.k)),
    .rdata (b_rd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_q <= 1'b0;
      p_vld <= 1'b0;
    end else begin
      vld_q <= tag_in.valid;
      p_vld <= vld_q;
    end
  end

  // B read data lines up with the registered A element
  always_ff @(posedge clk) begin
    k_q  <= tag_in.k;
    a_q  <= a_in;
    prod <= a_q * b_rd;
  end

  always_ff @(posedge clk) begin
    if (ctl.clr) begin
      acc <= start_sum;
    end else if (ctl.shift) begin
      acc <= acc_in;
    end else if (p_vld) begin
      acc <= acc + SW'(prod);
    end
  end

  assign tag_out = '{valid: vld_q, k: k_q};
  assign a_out   = a_q;
  assign acc_out = acc;

endmodule

/* hw/rtl/integer_matrix_multiply.sv */
// ----------------------------------------------------------------------------
// integer_matrix_multiply
// Integer matrix multiplier: loads A and B element by element and emits one
// row of A x B plus the start value per compute request that names a row of A.
// ----------------------------------------------------------------------------
// A compute request for a row of A first feeds the row's terms, then drains
// the chain and then emits b_cols output transactions, one per cycle without
// stall; when a_cols and b_rows differ it goes straight to output, as then
// every element is the start value. The time is set by the chain of cells,
// one per product column: A is read one element per cycle and each element
// walks down the chain one cell per cycle, so the last column finishes only
// once the last term has passed through the whole chain.
// Loads are taken while results are still being delivered; a new compute
// request waits until the current row has been fully delivered.
module integer_matrix_multiply #(
  parameter int MAX_DIM    = 16,
  parameter int DATA_WIDTH = 16
) (
  input  logic                                  clk,
  input  logic                                  rst,
  // configuration
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [imm_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [imm_pkg::CFG_DATA_W-1:0]        cfg_data,
  // requests
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic [imm_pkg::REQ_W-1:0]             req_type,
  input  logic [imm_pkg::IDX_W-1:0]             row,
  input  logic [imm_pkg::IDX_W-1:0]             col,
  input  logic signed [imm_pkg::VAL_W-1:0]      value,
  // results
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic [imm_pkg::IDX_W-1:0]             out_row,
  output logic [imm_pkg::IDX_W-1:0]             out_col,
  output logic signed [imm_pkg::SUM_W-1:0]      sum,
  output logic                                  last
);

  localparam int EFF_DIM   = (MAX_DIM < imm_pkg::INDEX_LIMIT) ? MAX_DIM
                                                              : imm_pkg::INDEX_LIMIT;
  localparam int A_DEPTH   = EFF_DIM * EFF_DIM;
  localparam int A_AW      = $clog2(A_DEPTH);
  localparam int DRAIN_LEN = EFF_DIM + 2;
  localparam int DRAIN_W   = $clog2(DRAIN_LEN + 1);
  localparam int DW        = imm_pkg::DIM_W;
  localparam int IW        = imm_pkg::IDX_W;
  localparam int SW        = imm_pkg::SUM_W;
  localparam logic [DW-1:0] EFF_V = DW'(EFF_DIM);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_FEED  = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;
  localparam logic [1:0] ST_EMIT  = 2'd3;

  // configuration registers
  logic [DW-1:0]                     a_rows;
  logic [DW-1:0]                     a_cols;
  logic [DW-1:0]                     b_rows;
  logic [DW-1:0]                     b_cols;
  logic signed [imm_pkg::START_W-1:0] start_value;

  logic [DW-1:0] ar_eff, ac_eff, br_eff, bc_eff, terms;

  // sequencer
  logic [1:0]         state;
  logic [DW-1:0]      k_cnt;
  logic [DW-1:0]      n_terms;
  logic [DW-1:0]      n_cols;
  logic [IW-1:0]      cur_row;
  logic [IW-1:0]      col_cnt;
  logic [DRAIN_W-1:0] drain_cnt;
  logic               fv;
  logic [IW-1:0]      fk;

  logic in_acc, out_acc, load_a, load_b, start_row;

  logic signed [DATA_WIDTH-1:0] elem;
  logic [DATA_WIDTH-1:0]        a_rd;
  logic signed [SW-1:0]         start_sum;
  imm_pkg::ctl_t                ctl;

  imm_pkg::tag_t                tags  [EFF_DIM+1];
  logic signed [DATA_WIDTH-1:0] avals [EFF_DIM+1];
  logic signed [SW-1:0]         accs  [EFF_DIM+1];

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_rows      <= DW'(16);
      a_cols      <= DW'(16);
      b_rows      <= DW'(16);
      b_cols      <= DW'(16);
      start_value <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        imm_pkg::CFG_A_ROWS: a_rows <= cfg_data[DW-1:0];
        imm_pkg::CFG_A_COLS: a_cols <= cfg_data[DW-1:0];
        imm_pkg::CFG_B_ROWS: b_rows <= cfg_data[DW-1:0];
        imm_pkg::CFG_B_COLS: b_cols <= cfg_data[DW-1:0];
        imm_pkg::CFG_START:  start_value <= cfg_data[imm_pkg::START_W-1:0];
        default: ;
      endcase
    end
  end

  assign ar_eff = (a_rows > EFF_V) ? EFF_V : a_rows;
  assign ac_eff = (a_cols > EFF_V) ? EFF_V : a_cols;
  assign br_eff = (b_rows > EFF_V) ? EFF_V : b_rows;
  assign bc_eff = (b_cols > EFF_V) ? EFF_V : b_cols;
  // size mismatch is judged on the raw registers
  assign terms  = (a_cols == b_rows) ? ac_eff : '0;

  assign in_stall = (state == ST_FEED) || (state == ST_DRAIN) ||
                    ((state == ST_EMIT) && (req_type == imm_pkg::REQ_COMPUTE));
  assign in_acc   = in_valid && !in_stall;
  assign out_acc  = out_valid && !out_stall;

  assign load_a    = in_acc && (req_type == imm_pkg::REQ_LOAD_A) &&
                     ({1'b0, row} < ar_eff) && ({1'b0, col} < ac_eff);
  assign load_b    = in_acc && (req_type == imm_pkg::REQ_LOAD_B) &&
                     ({1'b0, row} < br_eff) && ({1'b0, col} < bc_eff);
  assign start_row = in_acc && (req_type == imm_pkg::REQ_COMPUTE) &&
                     ({1'b0, row} < ar_eff) && (bc_eff != '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      fv    <= 1'b0;
    end else begin
      fv <= (state == ST_FEED);
      unique case (state)
        ST_IDLE: begin
          if (start_row) begin
            state <= (terms == '0) ? ST_EMIT : ST_FEED;
          end
        end
        ST_FEED: begin
          if (k_cnt == n_terms - DW'(1)) begin
            state <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          if (drain_cnt == '0) begin
            state <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (out_acc && last) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    fk <= k_cnt[IW-1:0];
    if (start_row) begin
      k_cnt   <= '0;
      n_terms <= terms;
      n_cols  <= bc_eff;
      cur_row <= row;
      col_cnt <= '0;
    end
    if (state == ST_FEED) begin
      k_cnt     <= k_cnt + DW'(1);
      drain_cnt <= DRAIN_W'(DRAIN_LEN);
    end
    if (state == ST_DRAIN) begin
      drain_cnt <= drain_cnt - DRAIN_W'(1);
    end
    if (out_acc) begin
      col_cnt <= col_cnt + IW'(1);
    end
  end

  assign elem = DATA_WIDTH'(value);

  imm_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (A_DEPTH)
  ) u_astore (
    .clk   (clk),
    .we    (load_a),
    .waddr (A_AW'(int'(row) * EFF_DIM + int'(col))),
    .wdata (elem),
    .raddr (A_AW'(int'(cur_row) * EFF_DIM + int'(k_cnt[IW-1:0]))),
    .rdata (a_rd)
  );

  assign start_sum = SW'(start_value);
  assign ctl       = '{clr: start_row, shift: out_acc};

  assign tags[0]        = '{valid: fv, k: fk};
  assign avals[0]       = a_rd;
  assign accs[EFF_DIM]  = '0;

  for (genvar j = 0; j < EFF_DIM; j++) begin : g_cell
    imm_cell #(
      .DATA_WIDTH (DATA_WIDTH),
      .EFF_DIM    (EFF_DIM),
      .COL        (j)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctl       (ctl),
      .start_sum (start_sum),
      .b_we      (load_b),
      .b_row     (row),
      .b_col     (col),
      .b_data    (elem),
      .tag_in    (tags[j]),
      .a_in      (avals[j]),
      .tag_out   (tags[j+1]),
      .a_out     (avals[j+1]),
      .acc_in    (accs[j+1]),
      .acc_out   (accs[j])
    );
  end

  assign out_valid = (state == ST_EMIT);
  assign out_row   = cur_row;
  assign out_col   = col_cnt;
  assign sum       = accs[0];
  assign last      = ({1'b0, col_cnt} == n_cols - DW'(1));

`ifndef SYNTHESIS
  // a row always begins with feeding terms or, when there are none (as on a size mismatch), with output
  a_start_row: assert property (@(posedge clk) disable iff (rst)
    start_row |=> (state == ST_FEED) || (state == ST_EMIT))
    else $error("compute request did not start a row");

  // no term may still be in flight once output begins
  a_chain_empty: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EMIT) |-> (!fv && !tags[EFF_DIM].valid))
    else $error("chain still busy during output");

  a_col_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ({1'b0, col_cnt} < n_cols))
    else $error("output column beyond b_cols");

  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    (out_acc && last) |=> (state == ST_IDLE))
    else $error("sequencer did not return to idle after the last column");

  a_feed_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FEED) |-> (k_cnt < n_terms))
    else $error("term index beyond a_cols");
`endif

endmodule

/* tb/integer_matrix_multiply_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// integer_matrix_multiply_test
// Self-checking bench for the integer matrix multiplier. Element loads and
// row computes are queued per size setting and driven with random gaps. A
// local copy of both matrices and the registers predicts every product
// element, and each result is checked against the oldest prediction while the
// result side stalls at random.
// ----------------------------------------------------------------------------
module integer_matrix_multiply_test;

  localparam logic [imm_pkg::REQ_W-1:0] REQ_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT   = 1000000;
  localparam int SETTLE_CYCLES = 64;
  localparam int SQUEEZE_LEN   = 400;

  typedef struct packed {
    logic [imm_pkg::REQ_W-1:0]        rq;
    logic [imm_pkg::IDX_W-1:0]        r;
    logic [imm_pkg::IDX_W-1:0]        c;
    logic signed [imm_pkg::VAL_W-1:0] v;
  } mat_req_t;

  typedef struct packed {
    logic [imm_pkg::IDX_W-1:0]        r;
    logic [imm_pkg::IDX_W-1:0]        c;
    logic signed [imm_pkg::SUM_W-1:0] s;
    logic                             l;
  } prod_elem_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                             cfg_valid = 1'b0;
  logic                             cfg_ready;
  logic [imm_pkg::CFG_IDX_W-1:0]    cfg_index = '0;
  logic [imm_pkg::CFG_DATA_W-1:0]   cfg_data  = '0;

  logic                             in_valid = 1'b0;
  logic                             in_stall;
  logic [imm_pkg::REQ_W-1:0]        req_type = '0;
  logic [imm_pkg::IDX_W-1:0]        row      = '0;
  logic [imm_pkg::IDX_W-1:0]        col      = '0;
  logic signed [imm_pkg::VAL_W-1:0] value    = '0;

  logic                             out_valid;
  logic                             out_stall = 1'b0;
  logic [imm_pkg::IDX_W-1:0]        out_row;
  logic [imm_pkg::IDX_W-1:0]        out_col;
  logic signed [imm_pkg::SUM_W-1:0] sum;
  logic                             last;

  integer_matrix_multiply DUT (
    .clk      (clk),
    .rst      (rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .req_type (req_type),
    .row      (row),
    .col      (col),
    .value    (value),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_row  (out_row),
    .out_col  (out_col),
    .sum      (sum),
    .last     (last)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predicted state: registers as written, and both matrices
  logic [imm_pkg::DIM_W-1:0]          sz_a_rows = 5'd16;
  logic [imm_pkg::DIM_W-1:0]          sz_a_cols = 5'd16;
  logic [imm_pkg::DIM_W-1:0]          sz_b_rows = 5'd16;
  logic [imm_pkg::DIM_W-1:0]          sz_b_cols = 5'd16;
  logic signed [imm_pkg::START_W-1:0] sum_seed  = '0;
  logic signed [imm_pkg::VAL_W-1:0]   a_mat [imm_pkg::INDEX_LIMIT][imm_pkg::INDEX_LIMIT];
  logic signed [imm_pkg::VAL_W-1:0]   b_mat [imm_pkg::INDEX_LIMIT][imm_pkg::INDEX_LIMIT];

  prod_elem_t product_q [$];
  mat_req_t   request_q [$];

  // Stimulus-side view of the current setting and of which elements hold data
  int gen_ar, gen_ac, gen_br, gen_bc;
  bit gen_match;
  bit a_loaded [imm_pkg::INDEX_LIMIT][imm_pkg::INDEX_LIMIT];
  bit b_loaded [imm_pkg::INDEX_LIMIT][imm_pkg::INDEX_LIMIT];

  int errors       = 0;
  int loads_done   = 0;
  int rows_done    = 0;
  int elems_done   = 0;
  int settings     = 0;
  int cycles       = 0;
  int send_gap     = 0;
  int stall_left   = 0;
  int squeeze_left = 0;
  bit squeeze_used = 1'b0;
  logic squeeze_arm = 1'b0;
  logic in_calm     = 1'b0;
  logic out_calm    = 1'b0;
  mat_req_t   next_req;
  prod_elem_t head_elem;

  function automatic int clip_dim(input int d);
    return (d > imm_pkg::INDEX_LIMIT) ? imm_pkg::INDEX_LIMIT : d;
  endfunction

  // Mostly short pauses, now and then a long one
  function automatic int pick_pause();
    int p;
    p = $urandom_range(0, 19);
    if (p < 14) return $urandom_range(1, 3);
    if (p < 19) return $urandom_range(4, 8);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [imm_pkg::VAL_W-1:0] rand_elem();
    case ($urandom_range(0, 9))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'h0000;
      3: return 16'hFFFF;
      default: return imm_pkg::VAL_W'($urandom);
    endcase
  endfunction

  // Update the matrices on a load, or queue the product row of a compute
  function automatic void track_matrix_op(input logic [imm_pkg::REQ_W-1:0] rq,
                                          input logic [imm_pkg::IDX_W-1:0] r,
                                          input logic [imm_pkg::IDX_W-1:0] c,
                                          input logic signed [imm_pkg::VAL_W-1:0] v);
    int ar, ac, br, bc;
    logic signed [imm_pkg::SUM_W-1:0] acc;
    prod_elem_t e;
    ar = clip_dim(int'(sz_a_rows));
    ac = clip_dim(int'(sz_a_cols));
    br = clip_dim(int'(sz_b_rows));
    bc = clip_dim(int'(sz_b_cols));
    case (rq)
      imm_pkg::REQ_LOAD_A: begin
        if (r < ar && c < ac) begin
          a_mat[r][c] = v;
          loads_done++;
        end
      end
      imm_pkg::REQ_LOAD_B: begin
        if (r < br && c < bc) begin
          b_mat[r][c] = v;
          loads_done++;
        end
      end
      imm_pkg::REQ_COMPUTE: begin
        if (r < ar) begin
          rows_done++;
          for (int j = 0; j < bc; j++) begin
            acc = sum_seed;
            // mismatch is judged on the raw register values
            if (sz_a_cols == sz_b_rows) begin
              for (int k = 0; k < ac; k++) acc = acc + a_mat[r][k] * b_mat[k][j];
            end
            e.r = r;
            e.c = imm_pkg::IDX_W'(j);
            e.s = acc;
            e.l = (j == bc - 1);
            product_q.push_back(e);
          end
        end
      end
      default: ;
    endcase
  endfunction

  // Driver: accept, then offer the next queued transaction, now and then after a gap
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      send_gap = 0;
    end else begin
      if (in_valid && !in_stall) track_matrix_op(req_type, row, col, value);
      if (!in_valid || !in_stall) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (request_q.size() > 0) begin
          next_req = request_q.pop_front();
          req_type <= next_req.rq;
          row      <= next_req.r;
          col      <= next_req.c;
          value    <= next_req.v;
          in_valid <= 1'b1;
          send_gap = (!in_calm && $urandom_range(0, 2) == 0) ? pick_pause() : 0;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Long hold-off of the result side, so that computes back up into the input
  always @(posedge clk) begin
    if (rst) begin
      squeeze_left <= 0;
    end else if (squeeze_arm && !squeeze_used) begin
      squeeze_left <= SQUEEZE_LEN;
      squeeze_used = 1'b1;
    end else if (squeeze_left > 0) begin
      squeeze_left <= squeeze_left - 1;
    end
  end

  // Monitor: check each accepted result, then pick the next stall
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (product_q.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("ERROR: unexpected result row %0d col %0d sum %0d last %0b",
                     out_row, out_col, sum, last);
        end else begin
          head_elem = product_q.pop_front();
          elems_done++;
          if (out_row !== head_elem.r || out_col !== head_elem.c ||
              sum !== head_elem.s || last !== head_elem.l) begin
            errors++;
            if (errors <= 10)
              $display("ERROR: expected row %0d col %0d sum %0d last %0b, got %0d %0d %0d %0b",
                       head_elem.r, head_elem.c, head_elem.s, head_elem.l,
                       out_row, out_col, sum, last);
          end
        end
      end
      if (squeeze_left > 0) begin
        out_stall <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else if (!out_calm && $urandom_range(0, 3) == 0) begin
        stall_left = pick_pause() - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && cfg_valid && cfg_ready) begin
      case (cfg_index)
        imm_pkg::CFG_A_ROWS: sz_a_rows <= cfg_data[imm_pkg::DIM_W-1:0];
        imm_pkg::CFG_A_COLS: sz_a_cols <= cfg_data[imm_pkg::DIM_W-1:0];
        imm_pkg::CFG_B_ROWS: sz_b_rows <= cfg_data[imm_pkg::DIM_W-1:0];
        imm_pkg::CFG_B_COLS: sz_b_cols <= cfg_data[imm_pkg::DIM_W-1:0];
        imm_pkg::CFG_START:  sum_seed  <= cfg_data;
        default: ;
      endcase
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycles);
      $display("Regression FAIL");
      $finish;
    end
  end

  // Leave cfg_valid high; the caller drops it after the last write
  task automatic write_reg(input logic [imm_pkg::CFG_IDX_W-1:0] idx,
                           input logic [imm_pkg::CFG_DATA_W-1:0] d);
    cfg_index <= idx;
    cfg_data  <= d;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  // Size registers get random upper bits, which the block drops
  task automatic configure(input int ar, input int ac, input int br, input int bc,
                           input logic [imm_pkg::CFG_DATA_W-1:0] seed, input bit squeeze);
    write_reg(imm_pkg::CFG_A_ROWS, (32'($urandom) & ~32'h1F) | 32'(ar));
    write_reg(imm_pkg::CFG_A_COLS, (32'($urandom) & ~32'h1F) | 32'(ac));
    write_reg(imm_pkg::CFG_B_ROWS, (32'($urandom) & ~32'h1F) | 32'(br));
    write_reg(imm_pkg::CFG_B_COLS, (32'($urandom) & ~32'h1F) | 32'(bc));
    write_reg(imm_pkg::CFG_START, seed);
    cfg_valid <= 1'b0;
    gen_ar    = clip_dim(ar);
    gen_ac    = clip_dim(ac);
    gen_br    = clip_dim(br);
    gen_bc    = clip_dim(bc);
    gen_match = (ar >= 0) && (ac == br);
    in_calm   <= ($urandom_range(0, 3) == 0);
    out_calm  <= ($urandom_range(0, 3) == 0);
    if (squeeze) squeeze_arm <= 1'b1;
    settings++;
  endtask

  // Returns 1 for a load that lands inside its matrix or a compute for a row of A
  task automatic push_req(input logic [imm_pkg::REQ_W-1:0] rq, input int r, input int c,
                          input logic [imm_pkg::VAL_W-1:0] v, output bit useful);
    mat_req_t it;
    it.rq = rq;
    it.r  = imm_pkg::IDX_W'(r);
    it.c  = imm_pkg::IDX_W'(c);
    it.v  = v;
    request_q.push_back(it);
    useful = 1'b0;
    if (rq == imm_pkg::REQ_LOAD_A && r < gen_ar && c < gen_ac) begin
      a_loaded[r][c] = 1'b1;
      useful = 1'b1;
    end else if (rq == imm_pkg::REQ_LOAD_B && r < gen_br && c < gen_bc) begin
      b_loaded[r][c] = 1'b1;
      useful = 1'b1;
    end else if (rq == imm_pkg::REQ_COMPUTE && r < gen_ar) begin
      useful = 1'b1;
    end
  endtask

  // Load whatever the row needs that is still empty, refresh some, then compute
  task automatic push_row_job(inout int count);
    int r;
    bit u;
    r = $urandom_range(0, gen_ar - 1);
    if (gen_match) begin
      for (int k = 0; k < gen_ac; k++) begin
        if (!a_loaded[r][k] || $urandom_range(0, 1) == 0) begin
          push_req(imm_pkg::REQ_LOAD_A, r, k, rand_elem(), u);
          count += u;
        end
      end
      for (int k = 0; k < gen_ac; k++) begin
        for (int j = 0; j < gen_bc; j++) begin
          if (!b_loaded[k][j] || $urandom_range(0, 7) == 0) begin
            push_req(imm_pkg::REQ_LOAD_B, k, j, rand_elem(), u);
            count += u;
          end
        end
      end
    end else if (gen_ac > 0) begin
      push_req(imm_pkg::REQ_LOAD_A, r, $urandom_range(0, gen_ac - 1), rand_elem(), u);
      count += u;
    end
    push_req(imm_pkg::REQ_COMPUTE, r, $urandom_range(0, 15), rand_elem(), u);
    count += u;
  endtask

  // Unused codes, loads anywhere, and computes for rows outside A
  task automatic push_noise(inout int count);
    bit u;
    case ($urandom_range(0, 3))
      0: push_req(REQ_UNUSED, $urandom_range(0, 15), $urandom_range(0, 15), rand_elem(), u);
      1: push_req(imm_pkg::REQ_LOAD_A, $urandom_range(0, 15), $urandom_range(0, 15),
                  rand_elem(), u);
      2: push_req(imm_pkg::REQ_LOAD_B, $urandom_range(0, 15), $urandom_range(0, 15),
                  rand_elem(), u);
      default: begin
        if (gen_ar < imm_pkg::INDEX_LIMIT)
          push_req(imm_pkg::REQ_COMPUTE, $urandom_range(gen_ar, 15), $urandom_range(0, 15),
                   rand_elem(), u);
        else
          push_req(REQ_UNUSED, $urandom_range(0, 15), $urandom_range(0, 15), rand_elem(), u);
      end
    endcase
    count += u;
  endtask

  task automatic run_random(input int budget);
    int count;
    int tries;
    count = 0;
    tries = 0;
    while (count < budget && tries < 4 * budget) begin
      tries++;
      if (gen_ar == 0 || $urandom_range(0, 4) == 0) push_noise(count);
      else push_row_job(count);
    end
  endtask

  // Wait for everything queued and predicted, then for the compute latency
  task automatic settle();
    while (request_q.size() != 0 || in_valid || product_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    bit u;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: extreme values, every request code, ignored loads and computes
    configure(2, 2, 2, 3, 32'h7FFF_FFFF, 1'b0);
    push_req(imm_pkg::REQ_LOAD_A, 0, 0, 16'h8000, u);
    push_req(imm_pkg::REQ_LOAD_A, 0, 1, 16'h7FFF, u);
    push_req(imm_pkg::REQ_LOAD_A, 1, 0, 16'hFFFF, u);
    push_req(imm_pkg::REQ_LOAD_A, 1, 1, 16'h0000, u);
    push_req(imm_pkg::REQ_LOAD_B, 0, 0, 16'h8000, u);
    push_req(imm_pkg::REQ_LOAD_B, 0, 1, 16'h7FFF, u);
    push_req(imm_pkg::REQ_LOAD_B, 0, 2, 16'hFFFF, u);
    push_req(imm_pkg::REQ_LOAD_B, 1, 0, 16'h8000, u);
    push_req(imm_pkg::REQ_LOAD_B, 1, 1, 16'h0001, u);
    push_req(imm_pkg::REQ_LOAD_B, 1, 2, 16'h7FFF, u);
    push_req(imm_pkg::REQ_COMPUTE, 0, 15, 16'h0000, u);
    push_req(imm_pkg::REQ_COMPUTE, 1, 0, 16'hFFFF, u);
    push_req(REQ_UNUSED, 0, 0, 16'h7FFF, u);
    push_req(imm_pkg::REQ_LOAD_A, 2, 0, 16'h1234, u);
    push_req(imm_pkg::REQ_LOAD_A, 0, 2, 16'h4321, u);
    push_req(imm_pkg::REQ_LOAD_B, 2, 0, 16'h5555, u);
    push_req(imm_pkg::REQ_LOAD_B, 0, 3, 16'hAAAA, u);
    push_req(imm_pkg::REQ_LOAD_A, 15, 15, 16'hFFFF, u);
    push_req(imm_pkg::REQ_COMPUTE, 2, 0, 16'h0000, u);
    push_req(imm_pkg::REQ_COMPUTE, 15, 15, 16'h0000, u);
    // ignored loads must have left row 0 alone
    push_req(imm_pkg::REQ_COMPUTE, 0, 0, 16'h0000, u);
    settle();

    configure(4, 3, 3, 5, 32'h8000_0000, 1'b0);
    run_random(40);
    settle();
    // same effective sizes, raw mismatch: every element is the start value
    configure(16, 16, 20, 16, 32'($urandom), 1'b0);
    run_random(25);
    settle();
    configure(16, 16, 16, 1, 32'($urandom), 1'b0);
    run_random(40);
    settle();
    configure(3, 1, 1, 16, 32'($urandom), 1'b0);
    run_random(30);
    settle();
    configure(0, 4, 4, 4, 32'($urandom), 1'b0);
    run_random(10);
    settle();
    // oversized registers clip to 16
    configure(31, 2, 2, 31, 32'($urandom), 1'b0);
    run_random(30);
    settle();
    configure(5, 0, 0, 3, 32'($urandom), 1'b0);
    run_random(15);
    settle();
    configure(2, 3, 3, 0, 32'($urandom), 1'b0);
    run_random(15);
    settle();
    configure(6, 4, 4, 6, 32'($urandom), 1'b1);
    run_random(50);
    settle();
    configure(8, 5, 6, 4, 32'($urandom), 1'b0);
    run_random(25);
    settle();

    $display("Ran %0d size settings: %0d element loads, %0d row computes, %0d elements checked",
             settings, loads_done, rows_done, elems_done);
    if (errors == 0 && product_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("%0d mismatches, %0d results missing", errors, product_q.size());
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
